/* hdl/fhc_pkg.sv */
// Package for the single/half floating-point format converter.
// Holds the shared codes, field constants and inter-stage structs.
// No dependencies.
package fhc_pkg;

  // Stream widths: single_bits then half_bits in, half_result then single_result out.
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 48;

  // Exponent field limits and rebias offset (127 - 15).
  localparam logic [7:0] S_EXP_MAX   = 8'hff;
  localparam logic [4:0] H_EXP_MAX   = 5'h1f;
  localparam logic [7:0] EXP_REBIAS  = 8'd112;
  // Single exponent fields at and above this overflow the half range.
  localparam logic [7:0] S_EXP_OVF   = 8'd143;
  // Single exponent fields below this flush to a signed zero.
  localparam logic [7:0] S_EXP_FLUSH = 8'd103;
  // Right shift for a half denormal is this minus the single exponent field.
  localparam logic [7:0] SUB_SH_BASE = 8'd126;
  // Quiet bit of a half NaN mantissa.
  localparam logic [9:0] H_QNAN      = 10'h200;

  // Conversion direction, carried in tuser.
  typedef enum logic {
    CMD_S2H = 1'b0,
    CMD_H2S = 1'b1
  } fhc_cmd_e;

  // Operand class after decode.
  typedef enum logic [1:0] {
    CLS_ZERO   = 2'd0,
    CLS_INFNAN = 2'd1,
    CLS_SUB    = 2'd2,
    CLS_NORM   = 2'd3
  } fhc_cls_e;

  // Decode stage result. expo holds the half exponent (single to half normal),
  // the right shift (single to half denormal), the leading-zero count (half
  // to single denormal) or the half exponent field (half to single normal).
  typedef struct packed {
    fhc_cmd_e    cmd;
    logic        sign;
    fhc_cls_e    cls;
    logic        nan;
    logic [4:0]  expo;
    logic [22:0] mant;
  } fhc_dec_t;

  // Shift stage result: magnitude without sign, plus the round-up bit.
  typedef struct packed {
    fhc_cmd_e    cmd;
    logic        sign;
    logic        rnd;
    logic [30:0] mag;
  } fhc_pack_t;

endpackage

/* hdl/fhc_decode.sv */
// First pipeline stage of the format converter: classifies the operand,
// rebiases the exponent and counts leading zeros of half denormals.
// Depends on fhc_pkg.
module fhc_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic              cmd_i,
  input  logic [31:0]       single_bits_i,
  input  logic [15:0]       half_bits_i,
  output logic              valid_o,
  input  logic              ready_i,
  output fhc_pkg::fhc_dec_t dec_o
);
  import fhc_pkg::*;

  logic       valid_q;
  fhc_dec_t   dec_d;
  fhc_dec_t   dec_q;
  logic [7:0] s_ef;
  logic [7:0] sub_sh;
  logic [7:0] norm_e;
  logic [4:0] h_ef;
  logic [9:0] h_mant;
  logic [3:0] lz;

  // Leading zeros of the half mantissa; the highest set bit wins.
  always_comb begin
    lz = 4'd9;
    for (int i = 0; i < 10; i++) begin
      if (h_mant[i]) begin
        lz = 4'(9 - i);
      end
    end
  end

  assign s_ef   = single_bits_i[30:23];
  assign sub_sh = SUB_SH_BASE - s_ef;
  assign norm_e = s_ef - EXP_REBIAS;
  assign h_ef   = half_bits_i[14:10];
  assign h_mant = half_bits_i[9:0];

  // Classify the operand for the selected direction.
  always_comb begin
    dec_d     = '0;
    dec_d.cmd = fhc_cmd_e'(cmd_i);
    if (dec_d.cmd == CMD_S2H) begin
      dec_d.sign = single_bits_i[31];
      dec_d.mant = single_bits_i[22:0];
      if (s_ef == S_EXP_MAX) begin
        dec_d.cls = CLS_INFNAN;
        dec_d.nan = |single_bits_i[22:0];
      end else if (s_ef >= S_EXP_OVF) begin
        dec_d.cls = CLS_INFNAN;
      end else if (s_ef < S_EXP_FLUSH) begin
        dec_d.cls = CLS_ZERO;
      end else if (s_ef <= EXP_REBIAS) begin
        dec_d.cls  = CLS_SUB;
        dec_d.expo = sub_sh[4:0];
      end else begin
        dec_d.cls  = CLS_NORM;
        dec_d.expo = norm_e[4:0];
      end
    end else begin
      dec_d.sign = half_bits_i[15];
      dec_d.mant = {13'd0, h_mant};
      if (h_ef == H_EXP_MAX) begin
        dec_d.cls = CLS_INFNAN;
      end else if (h_ef == 5'd0) begin
        if (h_mant == 10'd0) begin
          dec_d.cls = CLS_ZERO;
        end else begin
          dec_d.cls  = CLS_SUB;
          dec_d.expo = {1'b0, lz};
        end
      end else begin
        dec_d.cls  = CLS_NORM;
        dec_d.expo = h_ef;
      end
    end
  end

  // Stage register; it loads whenever the downstream stage makes room.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      dec_q <= dec_d;
    end
  end

  assign valid_o = valid_q;
  assign dec_o   = dec_q;

endmodule

/* hdl/fhc_shift.sv */
// Second pipeline stage of the format converter: denormalizes single values
// for half, normalizes half denormals and assembles the unsigned magnitude.
// Depends on fhc_pkg.
module fhc_shift (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  fhc_pkg::fhc_dec_t  dec_i,
  output logic               valid_o,
  input  logic               ready_i,
  output fhc_pkg::fhc_pack_t pack_o
);
  import fhc_pkg::*;

  logic       valid_q;
  fhc_pack_t  pack_d;
  fhc_pack_t  pack_q;
  logic [23:0] full;
  logic [23:0] shifted;
  logic [3:0]  lz;
  logic [10:0] nrm;
  logic [7:0]  sub_exp;
  logic [7:0]  norm_exp;

  // Single to half denormal: shift one short so the last dropped bit lands in bit 0.
  assign full    = {1'b1, dec_i.mant};
  assign shifted = full >> (dec_i.expo - 5'd1);

  // Half to single denormal: move the leading one into the hidden position.
  assign lz       = dec_i.expo[3:0];
  assign nrm      = {1'b0, dec_i.mant[9:0]} << (lz + 4'd1);
  assign sub_exp  = EXP_REBIAS - {4'd0, lz};
  assign norm_exp = {3'd0, dec_i.expo} + EXP_REBIAS;

  // Assemble the magnitude for each class.
  always_comb begin
    pack_d      = '0;
    pack_d.cmd  = dec_i.cmd;
    pack_d.sign = dec_i.sign;
    if (dec_i.cmd == CMD_S2H) begin
      case (dec_i.cls)
        CLS_ZERO:   pack_d.mag = '0;
        CLS_INFNAN: pack_d.mag = {16'd0, H_EXP_MAX, (dec_i.nan ? H_QNAN : 10'd0)};
        CLS_SUB: begin
          pack_d.mag = {21'd0, shifted[10:1]};
          pack_d.rnd = shifted[0];
        end
        CLS_NORM: begin
          pack_d.mag = {16'd0, dec_i.expo, dec_i.mant[22:13]};
          pack_d.rnd = dec_i.mant[12];
        end
        default:    pack_d.mag = '0;
      endcase
    end else begin
      case (dec_i.cls)
        CLS_ZERO:   pack_d.mag = '0;
        CLS_INFNAN: pack_d.mag = {S_EXP_MAX, dec_i.mant[9:0], 13'd0};
        CLS_SUB:    pack_d.mag = {sub_exp, nrm[9:0], 13'd0};
        CLS_NORM:   pack_d.mag = {norm_exp, dec_i.mant[9:0], 13'd0};
        default:    pack_d.mag = '0;
      endcase
    end
  end

  // Stage register.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      pack_q <= pack_d;
    end
  end

  assign valid_o = valid_q;
  assign pack_o  = pack_q;

endmodule

/* hdl/fhc_round.sv */
// Third pipeline stage of the format converter: applies the half-up round
// increment, attaches the sign and holds the output item.
// Depends on fhc_pkg.
module fhc_round (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  fhc_pkg::fhc_pack_t pack_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic [15:0]        half_result_o,
  output logic [31:0]        single_result_o
);
  import fhc_pkg::*;

  logic        valid_q;
  logic [15:0] half_d;
  logic [15:0] half_q;
  logic [31:0] single_d;
  logic [31:0] single_q;

  // The round carry may ripple through the exponent, up to infinity.
  always_comb begin
    half_d   = '0;
    single_d = '0;
    if (pack_i.cmd == CMD_S2H) begin
      half_d = {pack_i.sign, pack_i.mag[14:0]} + {15'd0, pack_i.rnd};
    end else begin
      single_d = {pack_i.sign, pack_i.mag};
    end
  end

  // Output register; it takes a new item as the current one leaves.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      half_q   <= half_d;
      single_q <= single_d;
    end
  end

  assign valid_o         = valid_q;
  assign half_result_o   = half_q;
  assign single_result_o = single_q;

endmodule

/* hdl/float_half_format_converter.sv */
// Converts IEEE binary32 to binary16 (tuser low) or binary16 to binary32
// (tuser high), one item per clock cycle while m_axis_tready is high. An item
// accepted on the slave side passes through three register stages (decode,
// shift and round) before it is presented on the master side. Single to half
// rounds half-up on the first dropped bit, flushes far underflow to a signed
// zero, gives infinity on overflow and a quiet NaN for any NaN; half to single
// is exact. Back-pressure reaches s_axis_tready combinationally through the
// stage enables, so a stall neither drops nor repeats an item.
// Depends on fhc_pkg, fhc_decode, fhc_shift and fhc_round.
module float_half_format_converter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: single_bits [31:0], half_bits [47:32]
  input  logic [fhc_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser: cmd [0]
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: half_result [15:0], single_result [47:16]
  output logic [fhc_pkg::OutDataW-1:0]  m_axis_tdata
);
  import fhc_pkg::*;

  logic      dec_valid;
  logic      dec_ready;
  fhc_dec_t  dec;
  logic      pack_valid;
  logic      pack_ready;
  fhc_pack_t pack;
  logic [15:0] half_result;
  logic [31:0] single_result;

  // Stage one: classify and rebias.
  fhc_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (s_axis_tvalid),
    .ready_o       (s_axis_tready),
    .cmd_i         (s_axis_tuser),
    .single_bits_i (s_axis_tdata[31:0]),
    .half_bits_i   (s_axis_tdata[47:32]),
    .valid_o       (dec_valid),
    .ready_i       (dec_ready),
    .dec_o         (dec)
  );

  // Stage two: denormalize or normalize, assemble the magnitude.
  fhc_shift u_shift (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_valid),
    .ready_o (dec_ready),
    .dec_i   (dec),
    .valid_o (pack_valid),
    .ready_i (pack_ready),
    .pack_o  (pack)
  );

  // Stage three: round and hold the output item.
  fhc_round u_round (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (pack_valid),
    .ready_o         (pack_ready),
    .pack_i          (pack),
    .valid_o         (m_axis_tvalid),
    .ready_i         (m_axis_tready),
    .half_result_o   (half_result),
    .single_result_o (single_result)
  );

  assign m_axis_tdata = {single_result, half_result};

  // An accepted item with no stall behind it is presented on the master side.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready
      |=> m_axis_tvalid)
    else $error("item not delivered after three unstalled cycles");

  // A single to half item leaves the binary32 field at zero.
  a_s2h_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pack_valid && pack_ready && pack.cmd == CMD_S2H) |=> (single_result == 32'd0))
    else $error("binary32 field not zero for a single to half item");

  // A half to single item leaves the binary16 field at zero.
  a_h2s_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pack_valid && pack_ready && pack.cmd == CMD_H2S) |=> (half_result == 16'd0))
    else $error("binary16 field not zero for a half to single item");

  // With the decode, shift and output registers all empty, the pipeline never refuses an item.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid && !pack_valid && !dec_valid) |-> s_axis_tready)
    else $error("input refused while the pipeline is empty");

endmodule
